// File: hw/rtl/scc_pkg.sv
package scc_pkg;

  localparam int FRAME_BYTES_DEF = 9;
  localparam int IDX_W           = 4;

  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam logic [7:0] TEMP_MAX  = 8'h7F;
  localparam logic       ST_OK     = 1'b0;
  localparam logic       ST_BADCRC = 1'b1;

  typedef struct packed {
    logic signed [7:0] temperature;
    logic              status;
  } result_t;

endpackage

// File: hw/rtl/scc_frame.sv
module scc_frame
  import scc_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(FRAME_BYTES - 1);

  logic [IDX_W-1:0] idx;
  logic [7:0]       crc;
  logic [7:0]       reading_low;
  logic [7:0]       reading_high;
  logic             is_last;
  logic [7:0]       crc_next;
  logic [7:0]       t_raw;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] b);
    logic [7:0] c;
    c = c_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  assign is_last  = (idx >= LAST);
  assign crc_next = crc8_byte(crc, data_byte);
  assign t_raw    = {reading_high[3:0], reading_low[7:4]};

  always_comb begin
    res_valid = accept && is_last;
    if (crc == data_byte) begin
      res.status = ST_OK;
      if (reading_low[3] && (t_raw != TEMP_MAX)) begin
        res.temperature = t_raw + 8'd1;
      end else begin
        res.temperature = t_raw;
      end
    end else begin
      res.status      = ST_BADCRC;
      res.temperature = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      crc          <= '0;
      reading_low  <= '0;
      reading_high <= '0;
    end else if (accept) begin
      if (is_last) begin
        idx <= '0;
        crc <= '0;
      end else begin
        idx <= idx + 1'b1;
        crc <= crc_next;
        if (idx == '0) begin
          reading_low <= data_byte;
        end
        if (idx == IDX_W'(1)) begin
          reading_high <= data_byte;
        end
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst) idx <= LAST)
    else $error("frame position beyond last byte");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (idx == '0) && (crc == '0))
    else $error("frame did not restart after closing byte");

endmodule

// File: hw/rtl/scc_out.sv
module scc_out
  import scc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_res,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    main_valid;
  result_t main_res;
  logic    skid_valid;
  result_t skid_res;
  logic    main_free;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;
  assign main_free = !main_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (main_free) begin
        if (skid_valid) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_valid <= in_valid;
        end
      end else if (in_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_res <= skid_valid ? skid_res : in_res;
    end
    if (!main_free && in_valid) begin
      skid_res <= in_res;
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held with empty output register");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (in_valid && main_valid && !out_ready) |=> skid_valid)
    else $error("result lost while output stalled");

endmodule

// File: hw/rtl/scratchpad_crc_check_and_temperature_core.sv
// Scratchpad CRC check and temperature extraction.
// Input stream (s_*): one scratchpad byte per transaction, FRAME_BYTES per
// frame. Every byte but the last goes through a reflected CRC-8 (poly 0x8C,
// init 0); bytes 0 and 1 are kept as the little-endian reading.
// Output stream (m_*): one transaction per frame, issued for the last byte.
// m_tdata carries the rounded signed temperature (0 on CRC failure), m_tuser
// the status (0 CRC match, 1 mismatch).
// Throughput: one byte per cycle while s_tready is high. The byte-wide CRC update
// is one level of unrolled logic in front of the CRC register.
// A result is registered in the output stage when its last byte is accepted.
// Stall: a two-entry output stage (output register plus skid register) keeps
// s_tready high while one result waits; s_tready drops only when both hold
// results, and no result is dropped.
// Reset (rst, synchronous): frame position, CRC and reading clear; pending
// results are discarded.
module scratchpad_crc_check_and_temperature_core
  import scc_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] temperature
  output logic       m_tuser    // [0] status
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = s_tvalid && s_tready;

  scc_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  scc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = out_res.temperature;
  assign m_tuser = out_res.status;

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scc_pkg::*;

  localparam int FRAME_LEN    = FRAME_BYTES_DEF;
  localparam int RAND_FRAMES  = 164;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 150;
  localparam int CALM_FROM    = 1200;
  localparam int CALM_TO      = 1600;
  localparam int REPORT_CAP   = 40;

  typedef struct packed {
    logic [7:0]        data;
    logic              seal;
    logic              spoil;
    logic              typed;
    logic signed [7:0] t;
    logic              st;
  } plan_row_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              typed;
    logic signed [7:0] t;
    logic              st;
  } feed_t;

  // per row: byte, close with good CRC, close with corrupted CRC, typed, temp, status
  localparam plan_row_t PLAN [0:26] = '{
    '{8'hF8, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h07, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h01, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h80, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h7F, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'hFE, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h00, 1'b1, 1'b0, 1'b1, 8'sd127, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h55, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'hAA, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h0F, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'hF0, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h33, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'hCC, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b1, 1'b1, 8'sd0, ST_BADCRC},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h08, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h10, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h20, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h40, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h04, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h02, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h01, 1'b0, 1'b0, 1'b0, 8'sd0, ST_OK},
    '{8'h00, 1'b1, 1'b0, 1'b1, -8'sd128, ST_OK}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;

  scratchpad_crc_check_and_temperature_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  feed_t   feed_q[$];
  result_t temps_due[$];

  int  errs     = 0;
  int  cyc      = 0;
  int  rx_count = 0;
  bit  in_fire  = 1'b0;
  bit  hold_rx  = 1'b0;

  logic [7:0] frame_crc = 8'h00;
  logic [3:0] frame_pos = 4'd0;
  logic [7:0] reading_lo = 8'h00;
  logic [7:0] reading_hi = 8'h00;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (errs < REPORT_CAP) begin
      $display("mismatch @%0t: %s", $realtime, msg);
    end
    errs++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic typed,
                           input logic signed [7:0] t, input logic st);
    feed_t it;
    it.data  = b;
    it.typed = typed;
    it.t     = t;
    it.st    = st;
    feed_q.push_back(it);
  endtask

  task automatic queue_frame();
    logic [7:0] crc;
    logic [7:0] b;
    int         roll;
    crc  = 8'h00;
    roll = $urandom_range(0, 99);
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      b = 8'($urandom_range(0, 255));
      if (roll < 12 && i == 0) begin
        b = {4'hF, 1'b1, 3'($urandom_range(0, 7))};
      end else if (roll < 12 && i == 1) begin
        b = 8'h07;
      end
      crc = crc8_step(crc, b);
      push_byte(b, 1'b0, 8'sd0, ST_OK);
    end
    if (roll < 75) begin
      b = crc;
    end else if (roll < 90) begin
      b = crc ^ 8'($urandom_range(1, 255));
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    push_byte(b, 1'b0, 8'sd0, ST_OK);
  endtask

  task automatic absorb_byte(input feed_t it);
    result_t    r;
    logic [15:0] raw;
    logic [7:0]  t;
    if (int'(frame_pos) < FRAME_LEN - 1) begin
      if (frame_pos == 4'd0) begin
        reading_lo = it.data;
      end else if (frame_pos == 4'd1) begin
        reading_hi = it.data;
      end
      frame_crc = crc8_step(frame_crc, it.data);
      frame_pos = frame_pos + 4'd1;
    end else begin
      if (frame_crc == it.data) begin
        raw = {reading_hi, reading_lo};
        t   = raw[11:4];
        if (reading_lo[3] && t != TEMP_MAX) begin
          t = t + 8'd1;
        end
        r.temperature = t;
        r.status      = ST_OK;
      end else begin
        r.temperature = 8'sd0;
        r.status      = ST_BADCRC;
      end
      if (it.typed) begin
        r.temperature = it.t;
        r.status      = it.st;
      end
      temps_due.push_back(r);
      frame_crc = 8'h00;
      frame_pos = 4'd0;
    end
  endtask

  always @(posedge clk) begin
    feed_t   it;
    result_t want;
    if (!rst) begin
      cyc++;
      if (cyc >= CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        in_fire = s_tvalid && s_tready;
        if (in_fire) begin
          it = feed_q.pop_front();
          absorb_byte(it);
        end
        if (m_tvalid && m_tready) begin
          rx_count++;
          if (temps_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result temp %0d status %0b",
                                    $signed(m_tdata), m_tuser));
          end else begin
            want = temps_due.pop_front();
            if (m_tdata !== want.temperature) begin
              flag_mismatch($sformatf("result %0d temperature %0d, want %0d", rx_count,
                                      $signed(m_tdata), want.temperature));
            end
            if (m_tuser !== want.status) begin
              flag_mismatch($sformatf("result %0d status %0b, want %0b", rx_count,
                                      m_tuser, want.status));
            end
          end
        end
      end
    end
  end

  wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (feed_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= feed_q[0].data;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_rx && (calm || $urandom_range(0, 99) >= 10);
    end
  end

  // hold off the receiver long enough for the output stage to fill and back up the input
  initial begin
    wait (rx_count >= 12);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    logic [7:0] gen_crc;
    logic [7:0] b;
    gen_crc = 8'h00;
    foreach (PLAN[i]) begin
      b = PLAN[i].data;
      if (PLAN[i].seal) begin
        b       = gen_crc;
        gen_crc = 8'h00;
      end else if (PLAN[i].spoil) begin
        b       = gen_crc ^ 8'hFF;
        gen_crc = 8'h00;
      end else begin
        gen_crc = crc8_step(gen_crc, b);
      end
      push_byte(b, PLAN[i].typed, PLAN[i].t, PLAN[i].st);
    end
    for (int f = 0; f < RAND_FRAMES; f++) begin
      queue_frame();
    end

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    wait (feed_q.size() == 0);
    wait (temps_due.size() == 0);
    repeat (20) @(posedge clk);
    if (errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/scc_pkg.sv
hw/rtl/scc_frame.sv
hw/rtl/scc_out.sv
hw/rtl/scratchpad_crc_check_and_temperature_core.sv
tb/tb.sv
